>>> hw/rtl/ssort_pkg.sv
// Shared sizes and types for the selection sort engine.
package ssort_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;

   // One store read returning from memory during a minimum scan.
   typedef struct packed {
      logic                  valid;
      logic [IDX_W-1:0]      idx;
      logic [DATA_WIDTH-1:0] data;
   } rd_beat_type;

   // Running result of the minimum scan for the current position.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] best_val;
      logic [IDX_W-1:0]      best_idx;
      logic [DATA_WIDTH-1:0] pos_val;
   } min_result_type;

endpackage

>>> hw/rtl/ssort_min_scan.sv
// Running minimum tracker fed by store reads, first index wins on ties.
module ssort_min_scan
   import ssort_pkg::*;
(
   input  logic             clock,
   input  rd_beat_type      beat,
   input  logic [IDX_W-1:0] pos,
   output min_result_type   result
);

   min_result_type result_ff;
   min_result_type result_in;

   always_comb begin
      result_in = result_ff;
      if (beat.valid) begin
         if (beat.idx == pos) begin
            // first read of a scan is the entry at the current position
            result_in.best_val = beat.data;
            result_in.best_idx = beat.idx;
            result_in.pos_val  = beat.data;
         end else if ($signed(beat.data) < $signed(result_ff.best_val)) begin
            result_in.best_val = beat.data;
            result_in.best_idx = beat.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

>>> hw/rtl/selection_sort_engine.sv
// Selection sort engine: loads a list, sorts it in a local RAM, streams it out sorted.
// Load: one request per cycle while idle; the last one sorts, or emits if n < 2.
// Sort: for each position, scan the unsorted entries, one store read per cycle,
// through a single comparator, then swap the minimum into place with two writes.
// Emit: per result, a store read, then an output register load; held by back-pressure.
// Reset clears control state only; store contents stay undefined until written.
module selection_sort_engine
   import ssort_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [DATA_WIDTH-1:0] value
   input  logic               req_tlast,   // last_in
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [DATA_WIDTH-1:0] sorted_value
   output logic               rsp_tlast,   // last_out
   output logic [0:0]         rsp_tuser    // [0] overflow
);

   localparam logic [2:0] S_LOAD    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DRAIN   = 3'd2;
   localparam logic [2:0] S_SWAP_A  = 3'd3;
   localparam logic [2:0] S_SWAP_B  = 3'd4;
   localparam logic [2:0] S_EMIT_RD = 3'd5;
   localparam logic [2:0] S_EMIT_LD = 3'd6;

   logic [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic                  ovf_ff, ovf_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic                  beat_valid_ff, beat_valid_in;
   logic [IDX_W-1:0]      beat_idx_ff, beat_idx_in;
   rd_beat_type           beat;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] out_val_ff, out_val_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic                  we;
   logic [IDX_W-1:0]      waddr;
   logic [DATA_WIDTH-1:0] wdata;
   logic [IDX_W-1:0]      raddr;
   logic                  rd_issue;

   logic                  req_fire;
   logic [CNT_W-1:0]      n_last;
   logic                  k_is_last;
   min_result_type        min_res;

   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign n_last     = n_ff - CNT_W'(1);
   assign k_is_last  = (CNT_W'(k_ff) == n_last);

   ssort_min_scan u_min_scan (
      .clock  (clock),
      .beat   (beat),
      .pos    (pos_ff),
      .result (min_res)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      k_in         = k_ff;
      we           = 1'b0;
      waddr        = count_ff[IDX_W-1:0];
      wdata        = req_tdata[DATA_WIDTH-1:0];
      raddr        = scan_ff;
      rd_issue     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_val_in   = out_val_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  we       = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  n_in    = count_in;
                  pos_in  = '0;
                  scan_in = '0;
                  k_in    = '0;
                  state_in = (count_in > CNT_W'(1)) ? S_SCAN : S_EMIT_RD;
               end
            end
         end
         S_SCAN: begin
            raddr    = scan_ff;
            rd_issue = 1'b1;
            if (CNT_W'(scan_ff) == n_last) begin
               state_in = S_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            // last read of the scan lands in the tracker this cycle
            state_in = S_SWAP_A;
         end
         S_SWAP_A: begin
            we       = 1'b1;
            waddr    = pos_ff;
            wdata    = min_res.best_val;
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            we     = 1'b1;
            waddr  = min_res.best_idx;
            wdata  = min_res.pos_val;
            pos_in = pos_ff + IDX_W'(1);
            if ((CNT_W'(pos_ff) + CNT_W'(2)) < n_ff) begin
               scan_in  = pos_ff + IDX_W'(1);
               state_in = S_SCAN;
            end else begin
               k_in     = '0;
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            raddr = k_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_EMIT_LD;
            end
         end
         S_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            out_val_in   = rdata_ff;
            out_last_in  = k_is_last;
            out_ovf_in   = ovf_ff;
            if (k_is_last) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = S_LOAD;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      beat_valid_in = rd_issue;
      beat_idx_in   = raddr;
   end

   // Store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      rdata_ff <= store_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         beat_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         beat_valid_ff <= beat_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      pos_ff       <= pos_in;
      scan_ff      <= scan_in;
      k_ff         <= k_in;
      beat_idx_ff  <= beat_idx_in;
      out_val_ff   <= out_val_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // read data joins the beat in the cycle after the address
   assign beat = {beat_valid_ff, beat_idx_ff, rdata_ff};

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = TDATA_W'(out_val_ff);
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_ovf_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count exceeds store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_W'(DEPTH)))
      else $error("overflow flagged while store not full");

   a_swap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWAP_A) |-> ((min_res.best_idx >= pos_ff)
                                  && (CNT_W'(min_res.best_idx) < n_ff)))
      else $error("minimum index outside unsorted range");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_LD) |-> !rsp_valid_ff)
      else $error("output register overwritten while holding a result");

   a_emit_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_LD) |-> ($past(state_ff) == S_EMIT_RD))
      else $error("output loaded without a store read");
`endif

endmodule
